/* rtl/rvg_pkg.sv */
// Shared constants, payload type and codes for the radial vignetting gain correction unit.
// No dependencies.
`timescale 1ns / 1ps

package rvg_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int IDX_W   = 7;
  localparam int VAL_W   = 20;
  localparam int COORD_W = 12;
  localparam int CTR_W   = 11;
  localparam int SCALE_W = 17;
  localparam int LEN_W   = 8;
  localparam int CH_W    = 8;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam int SQ_W    = 2 * COORD_W;     // square of a 12-bit magnitude
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_W  = 21;              // sqrt of (sum << 16)
  localparam int REM_W   = 2 * ROOT_W;
  localparam int PROD_W  = ROOT_W + 1 + SCALE_W;
  localparam int R_W     = PROD_W - 16;     // radius, 8 fractional bits
  localparam int FRAC_W  = 8;
  localparam int N_W     = R_W - FRAC_W;
  localparam int FAC_W   = VAL_W + FRAC_W + 1;
  localparam int DREM_W  = FAC_W + CH_W;

  localparam logic [FRAC_W:0] WT_ONE = (FRAC_W + 1)'(1 << FRAC_W);
  localparam logic [ROOT_W:0] HALF   = (ROOT_W + 1)'(1 << (FRAC_W - 1));

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_SCALE    = 2'd2,
    CFG_LENGTH   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } item_t;

endpackage

/* rtl/rvg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rvg_sqrt.sv */
// Pipelined integer square root of (sum << 16), one root bit per stage.
// Depends on rvg_pkg.
`timescale 1ns / 1ps

module rvg_sqrt
  import rvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  item_t             in_item,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output item_t             out_item
);

  logic              v    [ROOT_W+1];
  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  item_t             item [ROOT_W+1];

  assign v[0]    = in_valid;
  assign rem[0]  = REM_W'({in_sum, 16'b0});
  assign root[0] = '0;
  assign item[0] = in_item;

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - k;
    logic [REM_W-1:0] trial;
    logic             take;

    assign trial = (REM_W'(root[k-1]) << (B + 1)) | (REM_W'(1) << (2 * B));
    assign take  = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ce) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        item[k] <= item[k-1];
        rem[k]  <= take ? rem[k-1] - trial : rem[k-1];
        root[k] <= take ? (root[k-1] | (ROOT_W'(1) << B)) : root[k-1];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_item  = item[ROOT_W];

endmodule

/* rtl/radial_vignetting_gain_correction_unit.sv */
// Radial vignetting gain correction: top level with config registers, table and divider.
// Depends on rvg_pkg, rvg_sqrt and rvg_ram.
`timescale 1ns / 1ps

// Takes one transaction per clock while in_ready is high, table writes and pixels alike, and
// returns one corrected pixel per pixel transaction; table writes give no result. Each pixel passes
// through the 21-stage square root and the 8-stage restoring divider. The pipeline advances
// as a whole: while a result sits unaccepted at the output, in_ready is low. Table writes
// take effect in transaction order relative to pixels. Configuration may be written only
// when the pipeline is empty.
module radial_vignetting_gain_correction_unit
  import rvg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [IDX_W-1:0]     table_index,
  input  logic [VAL_W-1:0]     table_value,
  input  logic [COORD_W-1:0]   pixel_x,
  input  logic [COORD_W-1:0]   pixel_y,
  input  logic [CH_W-1:0]      red_in,
  input  logic [CH_W-1:0]      green_in,
  input  logic [CH_W-1:0]      blue_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      red_out,
  output logic [CH_W-1:0]      green_out,
  output logic [CH_W-1:0]      blue_out
);

  localparam int DIV_STAGES = CH_W;

  logic [CTR_W-1:0]   center_x;
  logic [CTR_W-1:0]   center_y;
  logic [SCALE_W-1:0] radius_scale;
  logic [LEN_W-1:0]   table_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius_scale <= SCALE_W'(1 << 16);
      table_length <= LEN_W'(128);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center_x     <= cfg_data[CTR_W-1:0];
        CFG_CENTER_Y: center_y     <= cfg_data[CTR_W-1:0];
        CFG_SCALE:    radius_scale <= cfg_data[SCALE_W-1:0];
        CFG_LENGTH:   table_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;

  // stage 1: squared offsets from the center
  item_t                   item_in;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      ax, ay;
  logic                    v_s1;
  logic [SQ_W-1:0]         sq_x, sq_y;
  item_t                   item_s1;

  assign item_in.op    = op_t'(operation);
  assign item_in.idx   = table_index;
  assign item_in.value = table_value;
  assign item_in.red   = red_in;
  assign item_in.green = green_in;
  assign item_in.blue  = blue_in;

  assign dx = $signed({1'b0, pixel_x}) - $signed({2'b0, center_x});
  assign dy = $signed({1'b0, pixel_y}) - $signed({2'b0, center_y});
  assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else if (ce) begin
      v_s1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_s1 <= item_in;
      sq_x    <= {{COORD_W{1'b0}}, ax} * {{COORD_W{1'b0}}, ax};
      sq_y    <= {{COORD_W{1'b0}}, ay} * {{COORD_W{1'b0}}, ay};
    end
  end

  // square root
  logic              v_sq;
  logic [ROOT_W-1:0] root_sq;
  item_t             item_sq;

  rvg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v_s1),
    .in_sum    (SUM_W'(sq_x) + SUM_W'(sq_y)),
    .in_item   (item_s1),
    .out_valid (v_sq),
    .out_root  (root_sq),
    .out_item  (item_sq)
  );

  // m1: scaled radius
  logic            v_m1;
  item_t           item_m1;
  logic [R_W-1:0]  r_m1;
  logic [PROD_W-1:0] prod;

  assign prod = ({1'b0, root_sq} + HALF) * radius_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
    end else if (ce) begin
      v_m1 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_m1 <= item_sq;
      r_m1    <= prod[PROD_W-1:16];
    end
  end

  // table addressing; table writes land here so they stay ordered with pixel reads
  logic [N_W-1:0]    n;
  logic [ADDR_W:0]   len;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [FRAC_W-1:0] frac;
  logic              tbl_we;
  logic [VAL_W-1:0]  rd_a, rd_b;

  assign n = r_m1[R_W-1:FRAC_W];

  always_comb begin
    priority if (table_length == '0) begin
      len = (ADDR_W + 1)'(1);
    end else if (32'(table_length) > TABLE_DEPTH) begin
      len = (ADDR_W + 1)'(TABLE_DEPTH);
    end else begin
      len = (ADDR_W + 1)'(table_length);
    end
  end

  always_comb begin
    priority if (n == '0) begin
      addr_a = '0;
      addr_b = '0;
      frac   = '0;
    end else if (32'(n) < 32'(len)) begin
      addr_a = ADDR_W'(n - N_W'(1));
      addr_b = ADDR_W'(n);
      frac   = r_m1[FRAC_W-1:0];
    end else begin
      addr_a = ADDR_W'(len - (ADDR_W + 1)'(1));
      addr_b = addr_a;
      frac   = '0;
    end
  end

  assign tbl_we = ce && v_m1 && (item_m1.op == OP_WRITE) &&
                  (32'(item_m1.idx) < TABLE_DEPTH);

  rvg_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ADDR_W'(item_m1.idx)),
    .wdata (item_m1.value),
    .re    (ce),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  rvg_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ADDR_W'(item_m1.idx)),
    .wdata (item_m1.value),
    .re    (ce),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  // rd: table data arrives; only pixels continue
  logic              v_rd;
  item_t             item_rd;
  logic [FRAC_W-1:0] f_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
    end else if (ce) begin
      v_rd <= v_m1 && (item_m1.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_rd <= item_m1;
      f_rd    <= frac;
    end
  end

  // pr: interpolation products
  logic             v_pr;
  item_t            item_pr;
  logic [FAC_W-1:0] pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pr <= 1'b0;
    end else if (ce) begin
      v_pr <= v_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_pr <= item_rd;
      pa      <= rd_a * (WT_ONE - {1'b0, f_rd});
      pb      <= rd_b * {1'b0, f_rd};
    end
  end

  // fa: interpolated factor, Q.24
  logic             v_fa;
  item_t            item_fa;
  logic [FAC_W-1:0] fac_fa;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_fa <= 1'b0;
    end else if (ce) begin
      v_fa <= v_pr;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_fa <= item_pr;
      fac_fa  <= pa + pb;
    end
  end

  // divider: stage 0 flags saturation (quotient > 255, or zero factor),
  // then one quotient bit per stage
  logic [CH_W-1:0]   chan [3];
  logic              v_dv   [DIV_STAGES+1];
  logic [FAC_W-1:0]  fac_dv [DIV_STAGES+1];
  logic [DREM_W-1:0] rem_dv [DIV_STAGES+1][3];
  logic [CH_W-1:0]   q_dv   [DIV_STAGES+1][3];
  logic [2:0]        sat_dv [DIV_STAGES+1];

  assign chan[0] = item_fa.red;
  assign chan[1] = item_fa.green;
  assign chan[2] = item_fa.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dv[0] <= 1'b0;
    end else if (ce) begin
      v_dv[0] <= v_fa;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fac_dv[0] <= fac_fa;
      for (int c = 0; c < 3; c++) begin
        sat_dv[0][c] <= FAC_W'({chan[c], 16'b0}) >= fac_fa;
        rem_dv[0][c] <= DREM_W'({chan[c], 24'b0});
        q_dv[0][c]   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    localparam int I = DIV_STAGES - j;
    logic [DREM_W-1:0] trial;

    assign trial = DREM_W'(fac_dv[j-1]) << I;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_dv[j] <= 1'b0;
      end else if (ce) begin
        v_dv[j] <= v_dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        fac_dv[j] <= fac_dv[j-1];
        sat_dv[j] <= sat_dv[j-1];
        for (int c = 0; c < 3; c++) begin
          if (rem_dv[j-1][c] >= trial) begin
            rem_dv[j][c] <= rem_dv[j-1][c] - trial;
            q_dv[j][c]   <= q_dv[j-1][c] | (CH_W'(1) << I);
          end else begin
            rem_dv[j][c] <= rem_dv[j-1][c];
            q_dv[j][c]   <= q_dv[j-1][c];
          end
        end
      end
    end
  end

  assign out_valid = v_dv[DIV_STAGES];
  assign red_out   = sat_dv[DIV_STAGES][0] ? '1 : q_dv[DIV_STAGES][0];
  assign green_out = sat_dv[DIV_STAGES][1] ? '1 : q_dv[DIV_STAGES][1];
  assign blue_out  = sat_dv[DIV_STAGES][2] ? '1 : q_dv[DIV_STAGES][2];

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_zero_factor_saturates: assert property (@(posedge clk) disable iff (rst)
    (v_dv[0] && fac_dv[0] == '0) |-> (sat_dv[0] == 3'b111))
    else $error("zero factor did not saturate all channels");

  a_result_leaves_on_ready: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

  a_no_write_during_pixel: assert property (@(posedge clk) disable iff (rst)
    tbl_we |=> !v_rd)
    else $error("table write passed on as a pixel");
`endif

endmodule
